// ----- sv/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the selective state-space scan
// Transaction structs, the queue entry format, back-end states and the
// base-2 exponent table.
// ----------------------------------------------------------------------------
`default_nettype none
package sss_pkg;

  localparam int unsigned CHANNELS_DEF = 1024;
  localparam int unsigned STATES_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;

  // log2(e) in Q16 and clamp bounds of the base-2 exponent (Q16.16)
  localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
  localparam logic signed [25:0] W_MIN     = -26'sd1114112;
  localparam logic signed [25:0] W_MAX     = 26'sd983039;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  typedef struct packed {
    logic               op;
    logic [9:0]         channel;
    logic [3:0]         state_index;
    logic               last_element;
    logic signed [15:0] delta;
    logic signed [15:0] x_sample;
    logic signed [15:0] a_coef;
    logic signed [15:0] b_coef;
    logic signed [15:0] c_coef;
    logic signed [31:0] init_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic [9:0]         out_channel;
  } out_item_t;

  // classified work item as held in the queue
  typedef struct packed {
    op_e                kind;
    logic               last;
    logic [9:0]         channel;
    logic [3:0]         state_index;
    logic signed [15:0] delta;
    logic signed [15:0] x_sample;
    logic signed [15:0] a_coef;
    logic signed [15:0] b_coef;
    logic signed [15:0] c_coef;
    logic signed [31:0] init_value;
  } work_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_EXP,
    ST_MANT,
    ST_SHIFT,
    ST_TERM,
    ST_SUM,
    ST_PROJ,
    ST_ACC
  } back_state_e;

  // round(2^(i/16) * 65536), i = 0..16
  function automatic logic [17:0] pow2_entry(input logic [4:0] idx);
    logic [17:0] v;
    case (idx)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      5'd16:   v = 18'd131072;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/sss_fifo.sv -----
// ----------------------------------------------------------------------------
// sss_fifo: work queue between front and back end
// Small register queue of classified work items, first in first out.
// ----------------------------------------------------------------------------
`default_nettype none
module sss_fifo #(
  parameter int unsigned DEPTH = sss_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sss_pkg::work_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output sss_pkg::work_t     head_o,
  output logic               empty_o
);
  import sss_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  work_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/sss_front.sv -----
// ----------------------------------------------------------------------------
// sss_front: input acceptance and classification
// Takes input transactions, drops those outside the state store and turns
// the rest into load or scan work items for the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sss_front #(
  parameter int unsigned CHANNELS = sss_pkg::CHANNELS_DEF,
  parameter int unsigned STATES   = sss_pkg::STATES_DEF
) (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sss_pkg::in_item_t in_item_i,
  input  wire logic             clearing_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output sss_pkg::work_t        q_data_o
);
  import sss_pkg::*;

  logic in_range;

  // slot bounds check
  assign in_range = ({7'd0, in_item_i.channel} < 17'(CHANNELS)) &&
                    ({5'd0, in_item_i.state_index} < 9'(STATES));

  assign in_ready_o = !clearing_i && !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o && in_range;

  // classify
  always_comb begin
    q_data_o.kind        = (in_item_i.op == 1'b1) ? OP_SCAN : OP_LOAD;
    q_data_o.last        = in_item_i.last_element;
    q_data_o.channel     = in_item_i.channel;
    q_data_o.state_index = in_item_i.state_index;
    q_data_o.delta       = in_item_i.delta;
    q_data_o.x_sample    = in_item_i.x_sample;
    q_data_o.a_coef      = in_item_i.a_coef;
    q_data_o.b_coef      = in_item_i.b_coef;
    q_data_o.c_coef      = in_item_i.c_coef;
    q_data_o.init_value  = in_item_i.init_value;
  end

endmodule
`default_nettype wire

// ----- sv/sss_back.sv -----
// ----------------------------------------------------------------------------
// sss_back: state store and scan datapath
// Holds the hidden-state memory, runs the exponent, state update and output
// accumulation one step per cycle bar output stalls; drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sss_back #(
  parameter int unsigned CHANNELS = sss_pkg::CHANNELS_DEF,
  parameter int unsigned STATES   = sss_pkg::STATES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sss_pkg::work_t q_head_i,
  input  wire logic           q_empty_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output sss_pkg::out_item_t  out_item_o
);
  import sss_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * STATES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [47:0] S32_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] S32_MIN = -48'sh0000_8000_0000;
  localparam logic signed [48:0] S48_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] S48_MIN = -49'sh0_8000_0000_0000;

  back_state_e state_q, state_d;

  logic signed [31:0] mem [DEPTH];
  logic               we;
  logic [AW-1:0]      wa, ra;
  logic signed [31:0] wd, rd_q;

  logic [AW:0]        clr_cnt_q;
  work_t              cur_q;
  logic [AW-1:0]      slot_q, head_slot;
  logic signed [31:0] h_q, p_q, dbc_q, hv_q;
  logic signed [21:0] w_q;
  logic signed [27:0] t2_q;
  logic [17:0]        m_q;
  logic [31:0]        abar_q;
  logic signed [47:0] t1_q, acc_q;
  logic signed [35:0] proj_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               pop_scan, acc_step, emit;

  // datapath wires
  logic signed [41:0] z_ext, lg_ext, wprod;
  logic signed [25:0] w_raw;
  logic signed [21:0] w_d;
  logic signed [47:0] dbc_ext, x_ext, t2prod;
  logic [4:0]         tab_i;
  logic [17:0]        tab_lo, tab_hi, tab_diff;
  logic [24:0]        interp;
  logic signed [5:0]  k_exp;
  logic [5:0]         nk;
  logic [31:0]        m_wide, abar_d;
  logic signed [64:0] abar_ext, h_ext, t1prod;
  logic signed [47:0] t2_ext, hsum;
  logic signed [31:0] hv_d;
  logic signed [47:0] cc_ext, hv_ext, pprod;
  logic signed [48:0] asum;
  logic signed [47:0] acc_new;
  logic signed [31:0] y_d;

  assign head_slot  = AW'(AW'(q_head_i.channel) * AW'(STATES) + AW'(q_head_i.state_index));
  assign clearing_o = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == (AW+1)'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (!q_empty_i && q_head_i.kind == OP_SCAN) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_EXP;
      ST_EXP:   state_d = ST_MANT;
      ST_MANT:  state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_TERM;
      ST_TERM:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_PROJ;
      ST_PROJ:  state_d = ST_ACC;
      ST_ACC:   if (!cur_q.last || !out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o  = 1'b0;
    pop_scan = 1'b0;
    we       = 1'b0;
    wa       = head_slot;
    wd       = q_head_i.init_value;
    acc_step = 1'b0;
    emit     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt_q[AW-1:0];
        wd = '0;
      end
      ST_IDLE: begin
        q_pop_o  = !q_empty_i;
        pop_scan = !q_empty_i && (q_head_i.kind == OP_SCAN);
        we       = !q_empty_i && (q_head_i.kind == OP_LOAD);
      end
      ST_PROJ: begin
        we = 1'b1;
        wa = slot_q;
        wd = hv_q;
      end
      ST_ACC: begin
        acc_step = !cur_q.last || !out_valid_q || out_ready_i;
        emit     = cur_q.last && acc_step;
      end
      default: ;
    endcase
  end

  assign ra = head_slot;

  // hidden-state memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // exponent: z * log2(e), clamped
  assign z_ext  = 42'($signed(p_q[31:8]));
  assign lg_ext = $signed({25'd0, LOG2E_Q16});
  assign wprod  = z_ext * lg_ext;
  assign w_raw  = wprod[41:16];
  assign w_d    = (w_raw < W_MIN) ? W_MIN[21:0] :
                  (w_raw > W_MAX) ? W_MAX[21:0] : w_raw[21:0];

  // input term delta*B*x
  assign dbc_ext = 48'(dbc_q);
  assign x_ext   = 48'(cur_q.x_sample);
  assign t2prod  = dbc_ext * x_ext;

  // mantissa interpolation
  assign tab_i    = {1'b0, w_q[15:12]};
  assign tab_lo   = pow2_entry(tab_i);
  assign tab_hi   = pow2_entry(tab_i + 5'd1);
  assign tab_diff = tab_hi - tab_lo;
  assign interp   = tab_diff[12:0] * w_q[11:0];

  // scale by 2^k
  assign k_exp  = w_q[21:16];
  assign nk     = 6'(-k_exp);
  assign m_wide = {14'd0, m_q};
  assign abar_d = k_exp[5] ? (m_wide >> nk[4:0]) : (m_wide << k_exp[3:0]);

  // decay term and saturated state
  assign abar_ext = $signed({33'd0, abar_q});
  assign h_ext    = 65'(h_q);
  assign t1prod   = abar_ext * h_ext;
  assign t2_ext   = 48'(t2_q);
  assign hsum     = t1_q + t2_ext;
  assign hv_d     = (hsum > S32_MAX) ? S32_MAX[31:0] :
                    (hsum < S32_MIN) ? S32_MIN[31:0] : hsum[31:0];

  // output projection and accumulation
  assign cc_ext  = 48'(cur_q.c_coef);
  assign hv_ext  = 48'(hv_q);
  assign pprod   = cc_ext * hv_ext;
  assign asum    = 49'(acc_q) + 49'(proj_q);
  assign acc_new = (asum > S48_MAX) ? S48_MAX[47:0] :
                   (asum < S48_MIN) ? S48_MIN[47:0] : asum[47:0];
  assign y_d     = (acc_new > S32_MAX) ? S32_MAX[31:0] :
                   (acc_new < S32_MIN) ? S32_MIN[31:0] : acc_new[31:0];

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_scan) begin
      cur_q  <= q_head_i;
      slot_q <= head_slot;
    end
    case (state_q)
      ST_MUL1: begin
        h_q   <= rd_q;
        p_q   <= 32'(cur_q.delta) * 32'(cur_q.a_coef);
        dbc_q <= 32'(cur_q.delta) * 32'(cur_q.b_coef);
      end
      ST_EXP: begin
        w_q  <= w_d;
        t2_q <= t2prod[47:20];
      end
      ST_MANT:  m_q    <= tab_lo + 18'(interp[24:12]);
      ST_SHIFT: abar_q <= abar_d;
      ST_TERM:  t1_q   <= t1prod[63:16];
      ST_SUM:   hv_q   <= hv_d;
      ST_PROJ:  proj_q <= pprod[47:12];
      default: ;
    endcase
    if (emit) begin
      out_q.y_value     <= y_d;
      out_q.out_channel <= cur_q.channel;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (acc_step) begin
        acc_q <= emit ? '0 : acc_new;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/selective_state_space_scan.sv -----
// ----------------------------------------------------------------------------
// selective_state_space_scan: fixed-point selective state-space scan
// Input transactions carry one (channel, state element) item: a load writes
// an initial hidden state, a scan updates h = exp(delta*A)*h + delta*B*x and
// adds C*h to a shared accumulator; a scan marked last emits y and the
// channel on the output channel and clears the accumulator.
// Both channels are valid/ready. Items outside the state store are taken
// and dropped. A four-entry queue parts the front end from the back end.
// After reset the back end zeroes all CHANNELS*STATES words of the state
// memory (16384 at the defaults), one word per cycle; input ready stays low
// during that pass.
// A load writes the state memory as the queue pops it. A scan is the pop
// that reads the state memory and eight steps of the one-item datapath
// (products, exponent, interpolation, shift, decay product, saturation,
// projection, accumulate); no new item leaves the queue until the scan ends.
// A scan marked last writes y to the output register. When the receiver
// stalls, the output register holds y and a further scan marked last waits
// in the back end while the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none
module selective_state_space_scan #(
  parameter int unsigned CHANNELS = sss_pkg::CHANNELS_DEF,
  parameter int unsigned STATES   = sss_pkg::STATES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sss_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sss_pkg::out_item_t     out_item_o
);
  import sss_pkg::*;

  logic  clearing, q_full, q_push, q_pop, q_empty;
  work_t q_data, q_head;

  // accept and classify
  sss_front #(
    .CHANNELS (CHANNELS),
    .STATES   (STATES)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_data)
  );

  // work queue
  sss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  // state store and datapath
  sss_back #(
    .CHANNELS (CHANNELS),
    .STATES   (STATES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_head_i    (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ----- verif/tb_selective_state_space_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_state_space_scan: self-checking bench of the scan block
// A queue of load/scan transactions (directed corner cases, then random
// channel sweeps with noise) feeds a clocked driver; a clocked monitor
// checks every y transaction against a bit-true fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_selective_state_space_scan;
  import sss_pkg::*;

  localparam int unsigned SLOTS      = CHANNELS_DEF * STATES_DEF;
  localparam int unsigned IDLE_LIMIT = 60000;
  localparam int unsigned N_RANDOM   = 1950;
  localparam longint      EXP_LO     = -17 * 65536;
  localparam longint      EXP_HI     = 15 * 65536 - 1;
  localparam longint      SUM_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      SUM_MIN    = -SUM_MAX - 1;

  typedef enum logic [1:0] {
    PH_FREE,
    PH_SRC_GAPS,
    PH_SINK_STALLS,
    PH_BOTH
  } phase_e;

  // 2^(i/16) in Q16, rounded
  localparam longint POW2_Q16 [17] = '{65536, 68438, 71468, 74632, 77936,
    81386, 84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098,
    120194, 125515, 131072};

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  in_item_t  pending_items[$];
  out_item_t y_expected[$];
  logic signed [31:0] h_model [SLOTS];
  longint    acc_model;

  int unsigned n_accepted;
  int unsigned n_loads;
  int unsigned n_scans;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned idle_cycles;
  logic        sink_hold;

  selective_state_space_scan u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic phase_e cur_phase();
    if (n_accepted < 500) return PH_FREE;
    if (n_accepted < 1000) return PH_SRC_GAPS;
    if (n_accepted < 1500) return PH_SINK_STALLS;
    return PH_BOTH;
  endfunction

  // base-2 exponent approximation of delta*A, Q16.16 result
  function automatic longint decay_factor(longint prod);
    longint z, w, k, r, m;
    int unsigned f, i;
    z = prod >>> 8;
    w = (z * 94548) >>> 16;
    if (w < EXP_LO) w = EXP_LO;
    if (w > EXP_HI) w = EXP_HI;
    k = w >>> 16;
    f = int'(w & 64'hFFFF);
    i = f >> 12;
    r = longint'(f & 32'hFFF);
    m = POW2_Q16[i] + (((POW2_Q16[i+1] - POW2_Q16[i]) * r) >>> 12);
    if (k >= 0) return m << k;
    return m >>> (-k);
  endfunction

  // update the state model for one accepted transaction
  task automatic scan_predict(input in_item_t it);
    int unsigned slot;
    longint h, hv, d;
    out_item_t y;
    slot = it.channel * STATES_DEF + it.state_index;
    if (it.op == OP_LOAD) begin
      h_model[slot] = it.init_value;
      n_loads++;
      return;
    end
    n_scans++;
    d  = longint'(it.delta);
    h  = longint'(h_model[slot]);
    hv = ((decay_factor(d * longint'(it.a_coef)) * h) >>> 16)
       + (((d * longint'(it.b_coef)) * longint'(it.x_sample)) >>> 20);
    if (hv > 64'sh7FFF_FFFF) hv = 64'sh7FFF_FFFF;
    if (hv < -64'sh8000_0000) hv = -64'sh8000_0000;
    h_model[slot] = hv[31:0];
    acc_model = acc_model + ((longint'(it.c_coef) * hv) >>> 12);
    if (acc_model > SUM_MAX) acc_model = SUM_MAX;
    if (acc_model < SUM_MIN) acc_model = SUM_MIN;
    if (it.last_element) begin
      if (acc_model > 64'sh7FFF_FFFF) y.y_value = 32'sh7FFF_FFFF;
      else if (acc_model < -64'sh8000_0000) y.y_value = 32'sh8000_0000;
      else y.y_value = acc_model[31:0];
      y.out_channel = it.channel;
      y_expected = {y_expected, y};
      acc_model = 0;
    end
  endtask

  // coefficient value: full range, small, or an extreme
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic in_item_t make_item(logic op, int unsigned ch, int unsigned si,
                                         logic last);
    in_item_t it;
    it.op           = op;
    it.channel      = ch[9:0];
    it.state_index  = si[3:0];
    it.last_element = last;
    it.delta        = pick16();
    it.x_sample     = pick16();
    it.a_coef       = pick16();
    it.b_coef       = pick16();
    it.c_coef       = pick16();
    it.init_value   = ($urandom_range(0, 1)) ? $urandom
                      : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    return it;
  endfunction

  task automatic push_fixed(logic op, int unsigned ch, int unsigned si, logic last,
                            logic [15:0] d, logic [15:0] a, logic [31:0] init);
    in_item_t it;
    it = make_item(op, ch, si, last);
    it.delta      = d;
    it.a_coef     = a;
    it.init_value = init;
    pending_items = {pending_items, it};
  endtask

  task automatic build_stimulus();
    int unsigned total, ch, n, steps;
    logic [15:0] d, x;
    in_item_t it;
    // directed corners: init extremes, exponent extremes, interleaving
    push_fixed(OP_LOAD, 0, 0, 1'b1, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
    push_fixed(OP_LOAD, 0, 1, 1'b0, 16'h0000, 16'h0000, 32'h8000_0000);
    push_fixed(OP_LOAD, 1023, 15, 1'b0, 16'h0000, 16'h0000, 32'h0001_0000);
    push_fixed(OP_SCAN, 0, 0, 1'b0, 16'h7FFF, 16'h7FFF, 32'h0);
    push_fixed(OP_SCAN, 0, 1, 1'b1, 16'h7FFF, 16'h7FFF, 32'h0);
    push_fixed(OP_SCAN, 0, 0, 1'b0, 16'h7FFF, 16'h8000, 32'h0);
    push_fixed(OP_SCAN, 0, 1, 1'b1, 16'h8000, 16'h7FFF, 32'h0);
    push_fixed(OP_SCAN, 1023, 15, 1'b1, 16'h8000, 16'h8000, 32'h0);
    push_fixed(OP_SCAN, 1023, 15, 1'b1, 16'h0000, 16'h1000, 32'h0);
    push_fixed(OP_SCAN, 1023, 15, 1'b1, 16'h1000, 16'hF000, 32'h0);
    push_fixed(OP_SCAN, 5, 3, 1'b0, 16'h0400, 16'hFC00, 32'h0);
    push_fixed(OP_SCAN, 9, 3, 1'b0, 16'h0400, 16'hFC00, 32'h0);
    push_fixed(OP_SCAN, 5, 4, 1'b1, 16'h0400, 16'hFC00, 32'h0);
    push_fixed(OP_LOAD, 5, 3, 1'b1, 16'h0000, 16'h0000, 32'hFFFF_0000);
    push_fixed(OP_SCAN, 5, 3, 1'b1, 16'h0010, 16'h0010, 32'h0);
    push_fixed(OP_SCAN, 0, 0, 1'b1, 16'hFFFF, 16'h0001, 32'h0);
    total = pending_items.size() + N_RANDOM;
    // random channel sweeps over time steps, with noise mixed in
    while (pending_items.size() < total) begin
      if ($urandom_range(0, 9) == 0) begin
        it = make_item($urandom_range(0, 1), $urandom_range(0, 1023),
                       $urandom_range(0, 15), $urandom_range(0, 1));
        pending_items = {pending_items, it};
        continue;
      end
      ch    = ($urandom_range(0, 1)) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
      n     = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 6);
      steps = $urandom_range(1, 3);
      if ($urandom_range(0, 2) == 0)
        for (int s = 0; s < n; s++)
          pending_items = {pending_items,
                           make_item(OP_LOAD, ch, s, $urandom_range(0, 1))};
      for (int t = 0; t < steps; t++) begin
        d = pick16();
        x = pick16();
        for (int s = 0; s < n; s++) begin
          it = make_item(OP_SCAN, ch, s, s == n - 1);
          it.delta    = d;
          it.x_sample = x;
          pending_items = {pending_items, it};
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        scan_predict(in_item);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 &&
            !((cur_phase() == PH_SRC_GAPS && $urandom_range(0, 99) < 87) ||
              (cur_phase() == PH_BOTH && $urandom_range(0, 99) < 35))) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (y_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected y transaction: y=%0d ch=%0d",
                     out_item.y_value, out_item.out_channel);
        end else begin
          want = y_expected.pop_front();
          if (want.y_value !== out_item.y_value ||
              want.out_channel !== out_item.out_channel) begin
            n_errors++;
            if (n_errors <= 10)
              $display("y mismatch: expected y=%0d ch=%0d, got y=%0d ch=%0d",
                       want.y_value, want.out_channel,
                       out_item.y_value, out_item.out_channel);
          end
        end
      end
      if (sink_hold)
        out_ready <= 1'b0;
      else if (cur_phase() == PH_SINK_STALLS)
        out_ready <= ($urandom_range(0, 99) >= 87);
      else if (cur_phase() == PH_BOTH)
        out_ready <= ($urandom_range(0, 99) >= 35);
      else
        out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_selective_state_space_scan: done, errors");
      $finish;
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    sink_hold = 1'b0;
    wait (n_accepted >= 300);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (600) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // main sequence
  initial begin
    n_accepted  = 0;
    n_loads     = 0;
    n_scans     = 0;
    n_results   = 0;
    n_errors    = 0;
    idle_cycles = 0;
    acc_model   = 0;
    foreach (h_model[i]) h_model[i] = '0;
    rst_ni = 1'b0;
    build_stimulus();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    wait (y_expected.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("covered %0d loads and %0d scan steps, %0d y transactions checked",
             n_loads, n_scans, n_results);
    $display("phases: free flow, sender gaps, receiver stalls, both, one long hold-off");
    if (n_errors == 0 && y_expected.size() == 0) begin
      $display("tb_selective_state_space_scan: done, clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_selective_state_space_scan: done, errors");
    end
    $finish;
  end

endmodule
